@@ rtl/smpq_pkg.sv @@
`default_nettype none
package smpq_pkg;

    // Queue geometry
    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int KEY_W = 16;
    localparam int TAG_W = 32;
    localparam int STAT_W = 2;

    // Request operation codes
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_LIST   = 1'b1;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_INSERTED = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_LISTED   = 2'd2;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd3;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } entry_t;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        logic   insert;
        logic   rotate;
        entry_t new_ent;
    } cell_ctl_t;

endpackage
`default_nettype wire

@@ rtl/smpq_in_if.sv @@
`default_nettype none
interface smpq_in_if;
    import smpq_pkg::*;

    logic             valid;
    logic             ready;
    logic             func;
    logic [KEY_W-1:0] fuel_key;
    logic [TAG_W-1:0] flight_tag;

    modport source (output valid, output func, output fuel_key, output flight_tag,
                    input ready);
    modport sink   (input valid, input func, input fuel_key, input flight_tag,
                    output ready);
endinterface
`default_nettype wire

@@ rtl/smpq_out_if.sv @@
`default_nettype none
interface smpq_out_if;
    import smpq_pkg::*;

    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [KEY_W-1:0]  out_key;
    logic [TAG_W-1:0]  out_tag;
    logic              last;

    modport source (output valid, output status, output out_key, output out_tag,
                    output last, input ready);
    modport sink   (input valid, input status, input out_key, input out_tag,
                    input last, output ready);
endinterface
`default_nettype wire

@@ rtl/stable_min_priority_queue_top.sv @@
`default_nettype none
// Sorted priority queue of up to DEPTH (16) entries, each a 16-bit key and a
// 32-bit tag, held in a row of shift cells in ascending key order; equal keys
// keep arrival order. On an insert request every cell compares its key with
// the new key in parallel and the row opens a slot in a single shift, so
// inserts are accepted back to back while results are taken. An insert into
// a full queue is dropped and answered with status full. A list request
// rotates the row one place per cycle past the head cell while results are
// taken, giving one result per stored entry (last marks the final one); the
// row is back in order when the rotation ends. A list of an empty queue
// gives one empty result.
module stable_min_priority_queue_top (
    input  wire logic   clk,
    input  wire logic   rst_n,
    smpq_in_if.sink     req,
    smpq_out_if.source  rsp
);
    import smpq_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_LIST = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  remain_reg, remain_next;
    logic              out_valid_reg, out_valid_next;
    logic [STAT_W-1:0] out_status_reg, out_status_next;
    entry_t            out_ent_reg, out_ent_next;
    logic              out_last_reg, out_last_next;

    cell_ctl_t ctl;
    entry_t    cell_ent [DEPTH];
    logic      cell_keep [DEPTH];
    logic      take;
    logic      acc;

    // Output slot is free when empty or being drained this cycle
    assign take      = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE) && take;
    assign acc       = req.valid && req.ready;

    // Row of cells
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic   occ;
        logic   tail;
        logic   lkeep;
        entry_t lent;
        entry_t rent;

        assign occ  = CNT_W'(i) < count_reg;
        assign tail = count_reg == CNT_W'(i + 1);

        if (i == 0)
        begin : g_head
            assign lkeep = 1'b1;
            assign lent  = ctl.new_ent;
        end
        else
        begin : g_body
            assign lkeep = cell_keep[i-1];
            assign lent  = cell_ent[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_end
            assign rent = cell_ent[i];
        end
        else
        begin : g_mid
            assign rent = cell_ent[i+1];
        end

        smpq_cell u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .occupied  (occ),
            .is_tail   (tail),
            .left_keep (lkeep),
            .left_ent  (lent),
            .right_ent (rent),
            .head_ent  (cell_ent[0]),
            .ent       (cell_ent[i]),
            .keep      (cell_keep[i])
        );
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        remain_next     = remain_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_ent_next    = out_ent_reg;
        out_last_next   = out_last_reg;
        ctl.insert      = 1'b0;
        ctl.rotate      = 1'b0;
        ctl.new_ent.key = req.fuel_key;
        ctl.new_ent.tag = req.flight_tag;

        case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    out_ent_next  = '0;
                    out_last_next = 1'b1;
                    if (req.func == FUNC_LIST)
                    begin
                        if (count_reg == '0)
                        begin
                            out_valid_next  = 1'b1;
                            out_status_next = STAT_EMPTY;
                        end
                        else
                        begin
                            state_next  = ST_LIST;
                            remain_next = count_reg;
                        end
                    end
                    else if (count_reg == CNT_W'(DEPTH))
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = STAT_FULL;
                    end
                    else
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = STAT_INSERTED;
                        ctl.insert      = 1'b1;
                        count_next      = count_reg + 1'b1;
                    end
                end
            end
            ST_LIST:
            begin
                if (take)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = STAT_LISTED;
                    out_ent_next    = cell_ent[0];
                    out_last_next   = remain_reg == CNT_W'(1);
                    ctl.rotate      = 1'b1;
                    remain_next     = remain_reg - 1'b1;
                    if (remain_reg == CNT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_ent_reg    <= out_ent_next;
        out_last_reg   <= out_last_next;
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.status  = out_status_reg;
    assign rsp.out_key = out_ent_reg.key;
    assign rsp.out_tag = out_ent_reg.tag;
    assign rsp.last    = out_last_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_list_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LIST) |-> !req.ready)
        else $error("request taken during list");

    a_list_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LIST) |=> (count_reg == $past(count_reg)))
        else $error("count changed by list");

    a_last_ends_list: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == STAT_LISTED && rsp.last) |-> (state_reg == ST_IDLE))
        else $error("list still running after last entry");

    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && count_reg >= CNT_W'(2))
            |-> (cell_ent[0].key <= cell_ent[1].key))
        else $error("head cells out of order");

endmodule
`default_nettype wire

@@ rtl/smpq_cell.sv @@
`default_nettype none
module smpq_cell (
    input  wire logic                clk,
    input  wire smpq_pkg::cell_ctl_t ctl,
    input  wire logic                occupied,
    input  wire logic                is_tail,
    input  wire logic                left_keep,
    input  wire smpq_pkg::entry_t    left_ent,
    input  wire smpq_pkg::entry_t    right_ent,
    input  wire smpq_pkg::entry_t    head_ent,
    output smpq_pkg::entry_t         ent,
    output logic                     keep
);
    import smpq_pkg::*;

    entry_t ent_reg;
    entry_t ent_next;

    // An occupied entry with key <= new key stays put (ties keep arrival order)
    assign keep = occupied && (ent_reg.key <= ctl.new_ent.key);
    assign ent  = ent_reg;

    // Insert: take the new entry at the boundary, shift right past it.
    // Rotate: move one place toward the head, tail wraps around from the head.
    always_comb
    begin
        ent_next = ent_reg;
        if (ctl.insert && !keep)
        begin
            ent_next = left_keep ? ctl.new_ent : left_ent;
        end
        else if (ctl.rotate)
        begin
            ent_next = is_tail ? head_ent : right_ent;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

endmodule
`default_nettype wire

@@ test/stable_min_priority_queue_top_tb.sv @@
`default_nettype none
module stable_min_priority_queue_top_tb;
    import smpq_pkg::*;

    localparam int          RANDOM_REQUESTS = 284;
    localparam int          HOLD_CYCLES     = 200;
    localparam int          FLOOD_REQUESTS  = 24;
    localparam int          TAIL_CYCLES     = 40;
    localparam int unsigned CYCLE_LIMIT     = 2000000;

    // One response beat as seen on the output channel
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [KEY_W-1:0]  key;
        logic [TAG_W-1:0]  tag;
        logic              last;
    } answer_t;

    // Opening stimulus row; a typed row carries its single status by hand
    typedef struct packed {
        logic              func;
        logic [KEY_W-1:0]  key;
        logic [TAG_W-1:0]  tag;
        logic              typed;
        logic [STAT_W-1:0] typed_status;
    } stim_row_t;

    logic clk;
    logic rst_n;

    smpq_in_if  req_if ();
    smpq_out_if rsp_if ();

    stable_min_priority_queue_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // Shadow copy of the sorted queue
    logic [KEY_W-1:0] held_keys [DEPTH];
    logic [TAG_W-1:0] held_tags [DEPTH];
    int               held_count;

    answer_t     model_out [$];
    answer_t     expected_answers [$];
    int unsigned mismatches;
    int unsigned cycle_count;
    bit          hold_off_pending;

    // Empty list, extremes, ties at every key position, then fill to full
    stim_row_t opening_rows [22] = '{
        '{FUNC_LIST,   16'h0000, 32'h0000_0000, 1'b1, STAT_EMPTY},
        '{FUNC_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, STAT_INSERTED},
        '{FUNC_INSERT, 16'h0000, 32'h0000_0000, 1'b1, STAT_INSERTED},
        '{FUNC_LIST,   16'h0000, 32'h0000_0000, 1'b0, STAT_INSERTED},
        '{FUNC_INSERT, 16'd100,  32'h0000_0001, 1'b0, STAT_INSERTED},
        '{FUNC_INSERT, 16'd100,  32'h0000_0002, 1'b0, STAT_INSERTED},
        '{FUNC_INSERT, 16'd100,  32'h0000_0003, 1'b0, STAT_INSERTED},
        '{FUNC_INSERT, 16'h0000, 32'h0000_0005, 1'b0, STAT_INSERTED},
        '{FUNC_INSERT, 16'hFFFF, 32'h0000_0006, 1'b0, STAT_INSERTED},
        '{FUNC_LIST,   16'hFFFF, 32'hFFFF_FFFF, 1'b0, STAT_INSERTED},
        '{FUNC_INSERT, 16'h8000, 32'h8000_0000, 1'b0, STAT_INSERTED},
        '{FUNC_INSERT, 16'h7FFF, 32'h7FFF_FFFF, 1'b0, STAT_INSERTED},
        '{FUNC_INSERT, 16'h0001, 32'h0000_0007, 1'b0, STAT_INSERTED},
        '{FUNC_INSERT, 16'hFFFE, 32'h0000_0008, 1'b0, STAT_INSERTED},
        '{FUNC_INSERT, 16'd100,  32'h0000_0009, 1'b0, STAT_INSERTED},
        '{FUNC_INSERT, 16'd50,   32'h0000_000A, 1'b0, STAT_INSERTED},
        '{FUNC_INSERT, 16'h5555, 32'hAAAA_AAAA, 1'b0, STAT_INSERTED},
        '{FUNC_INSERT, 16'hAAAA, 32'h5555_5555, 1'b0, STAT_INSERTED},
        '{FUNC_INSERT, 16'd200,  32'h0000_000B, 1'b0, STAT_INSERTED},
        '{FUNC_INSERT, 16'd300,  32'h0000_000C, 1'b1, STAT_FULL},
        '{FUNC_LIST,   16'h0000, 32'h0000_0000, 1'b0, STAT_INSERTED},
        '{FUNC_INSERT, 16'h0000, 32'h0000_0000, 1'b1, STAT_FULL}
    };

    // Clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Gap length: mostly none, some short, a few long
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Advance the shadow queue by one request; results land in model_out
    function automatic void step_sorted_queue(input logic f, input logic [KEY_W-1:0] k,
                                              input logic [TAG_W-1:0] t);
        int slot;
        model_out.delete();
        if (f == FUNC_INSERT)
        begin
            if (held_count >= DEPTH)
                model_out.push_back('{STAT_FULL, '0, '0, 1'b1});
            else
            begin
                // New entry goes after every equal key
                slot = 0;
                while (slot < held_count && held_keys[slot] <= k)
                    slot++;
                for (int i = held_count; i > slot; i--)
                begin
                    held_keys[i] = held_keys[i-1];
                    held_tags[i] = held_tags[i-1];
                end
                held_keys[slot] = k;
                held_tags[slot] = t;
                held_count++;
                model_out.push_back('{STAT_INSERTED, '0, '0, 1'b1});
            end
        end
        else if (held_count == 0)
            model_out.push_back('{STAT_EMPTY, '0, '0, 1'b1});
        else
        begin
            for (int i = 0; i < held_count; i++)
                model_out.push_back('{STAT_LISTED, held_keys[i], held_tags[i],
                                      (i == held_count - 1)});
        end
    endfunction

    // Offer one request, wait for acceptance, record expected results
    task automatic send_request(input logic f, input logic [KEY_W-1:0] k,
                                input logic [TAG_W-1:0] t, input logic typed,
                                input logic [STAT_W-1:0] typed_status,
                                input int unsigned gap);
        req_if.valid      <= 1'b1;
        req_if.func       <= f;
        req_if.fuel_key   <= k;
        req_if.flight_tag <= t;
        do
            @(posedge clk);
        while (req_if.ready !== 1'b1);
        step_sorted_queue(f, k, t);
        if (typed)
            expected_answers.push_back('{typed_status, '0, '0, 1'b1});
        else
            foreach (model_out[i])
                expected_answers.push_back(model_out[i]);
        if (gap != 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        while (expected_answers.size() != 0)
            @(posedge clk);
    endtask

    // Random request: inserts and lists in about equal share
    task automatic send_random(input int unsigned gap);
        logic             f;
        logic [KEY_W-1:0] k;
        int unsigned      roll;
        f    = ($urandom_range(0, 1) == 1) ? FUNC_LIST : FUNC_INSERT;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            k = '0;
        else if (roll == 1)
            k = '1;
        else
            k = KEY_W'($urandom_range(0, 65535));
        send_request(f, k, $urandom(), 1'b0, STAT_INSERTED, gap);
    endtask

    // Stimulus and end of run
    initial
    begin
        int unsigned gap;
        rst_n             = 1'b0;
        req_if.valid      = 1'b0;
        req_if.func       = FUNC_INSERT;
        req_if.fuel_key   = '0;
        req_if.flight_tag = '0;
        held_count        = 0;
        mismatches        = 0;
        hold_off_pending  = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening_rows[i])
            send_request(opening_rows[i].func, opening_rows[i].key, opening_rows[i].tag,
                         opening_rows[i].typed, opening_rows[i].typed_status, pick_gap());

        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (n == 100)
            begin
                // Sink holds off while requests keep coming, so the block backs up
                hold_off_pending = 1'b1;
                for (int j = 0; j < FLOOD_REQUESTS; j++)
                    send_random(0);
            end
            if (n == 200)
            begin
                req_if.valid <= 1'b0;
                wait_drained();
                @(posedge clk);
            end
            // Every fourth block of requests runs with no gaps
            gap = ((n / 32) % 4 == 3) ? 0 : pick_gap();
            send_random(gap);
        end
        req_if.valid <= 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Output side backpressure
    initial
    begin
        int unsigned run;
        int unsigned stall;
        rsp_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off_pending)
            begin
                hold_off_pending = 1'b0;
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                run   = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 12);
                stall = pick_gap();
                rsp_if.ready <= 1'b1;
                repeat (run) @(posedge clk);
                if (stall != 0)
                begin
                    rsp_if.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
        end
    end

    // Compare each accepted response with the oldest expectation
    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
        begin
            if (expected_answers.size() == 0)
            begin
                $error("unexpected response: status %0d key %0h tag %0h last %0b",
                       rsp_if.status, rsp_if.out_key, rsp_if.out_tag, rsp_if.last);
                mismatches++;
            end
            else
            begin
                want = expected_answers.pop_front();
                if (rsp_if.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp_if.status);
                    mismatches++;
                end
                if (rsp_if.out_key !== want.key)
                begin
                    $error("out_key: expected %0h, got %0h", want.key, rsp_if.out_key);
                    mismatches++;
                end
                if (rsp_if.out_tag !== want.tag)
                begin
                    $error("out_tag: expected %0h, got %0h", want.tag, rsp_if.out_tag);
                    mismatches++;
                end
                if (rsp_if.last !== want.last)
                begin
                    $error("last: expected %0b, got %0b", want.last, rsp_if.last);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("status: fail");
        $finish;
    end

endmodule
`default_nettype wire

@@ files.f @@
rtl/smpq_pkg.sv
rtl/smpq_in_if.sv
rtl/smpq_out_if.sv
rtl/smpq_cell.sv
rtl/stable_min_priority_queue_top.sv
test/stable_min_priority_queue_top_tb.sv
